// File: rtl/core/debounced_toggle_relay_controller_core_assert.svh
// Assertion macros used by the relay controller datapath.
`ifndef DEBOUNCED_TOGGLE_RELAY_CONTROLLER_CORE_ASSERT_SVH
`define DEBOUNCED_TOGGLE_RELAY_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DTRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTRC_ASSERT(lbl, prop, msg)
`define DTRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/dtrc_pkg.sv
// Shared constants, codes and interface types of the relay controller core.
package dtrc_pkg;

  localparam int HISTORY_DEPTH = 4;
  localparam int CHANNEL_COUNT = 32;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CHAN_MASK = ALL_ONES >> (32 - CHANNEL_COUNT);

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_BULK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DRIVE = 2'd0,
    KIND_LOCAL = 2'd1,
    KIND_BULK  = 2'd2
  } kind_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
  } dp_cmd_t;

  typedef struct packed {
    logic poll_fresh;
    logic pend_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/dtrc_ctrl.sv
// Controller state machine: accepts words and paces the press scan.
module dtrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  dtrc_pkg::dp_status_t status,
  output dtrc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = status.out_free;
        cmd.accept = in_tvalid && status.out_free;
        if (cmd.accept && status.poll_fresh) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = status.out_free;
        if (status.out_free && status.pend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/dtrc_datapath.sv
// Datapath: sample ring, debounce, relay word, press scan and output register.
`include "debounced_toggle_relay_controller_core_assert.svh"
module dtrc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [95:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  input  dtrc_pkg::dp_cmd_t    cmd,
  output dtrc_pkg::dp_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  logic [31:0] ring_r [dtrc_pkg::HISTORY_DEPTH];
  logic [31:0] ring_nxt [dtrc_pkg::HISTORY_DEPTH];
  logic [dtrc_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [31:0] relay_r, relay_nxt;
  logic [31:0] stable_r, stable_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic [31:0] omask_r, omask_nxt;
  logic        olast_r, olast_nxt;

  dtrc_pkg::op_t op;
  logic [31:0] sample, upd_mask, upd_val;
  logic [31:0] consensus, fresh, low, rest, toggled, merged;

  always_comb begin
    op       = dtrc_pkg::op_t'(in_tuser);
    sample   = in_tdata[31:0];
    upd_mask = in_tdata[63:32] & dtrc_pkg::CHAN_MASK;
    upd_val  = in_tdata[95:64];
    consensus = dtrc_pkg::CHAN_MASK;
    for (int i = 0; i < dtrc_pkg::HISTORY_DEPTH; i++) begin
      consensus = consensus &
        ((dtrc_pkg::SLOT_W'(i) == slot_r) ? sample : ring_r[i]);
    end
    fresh   = consensus & ~stable_r;
    low     = pend_r & (~pend_r + 32'd1);
    rest    = pend_r & ~low;
    toggled = relay_r ^ low;
    merged  = ((relay_r & ~upd_mask) | (upd_val & upd_mask)) & dtrc_pkg::CHAN_MASK;

    status.poll_fresh = (op == dtrc_pkg::OP_POLL) && (fresh != '0);
    status.pend_last  = (rest == '0);
    status.out_free   = !ov_r || out_tready;
  end

  always_comb begin
    ring_nxt   = ring_r;
    slot_nxt   = slot_r;
    relay_nxt  = relay_r;
    stable_nxt = stable_r;
    pend_nxt   = pend_r;
    ov_nxt     = ov_r && !out_tready;
    okind_nxt  = okind_r;
    oword_nxt  = oword_r;
    omask_nxt  = omask_r;
    olast_nxt  = olast_r;
    if (cmd.accept) begin
      unique case (op)
        dtrc_pkg::OP_POLL: begin
          ring_nxt[slot_r] = sample;
          slot_nxt = (slot_r == dtrc_pkg::SLOT_W'(dtrc_pkg::HISTORY_DEPTH - 1)) ?
                     '0 : slot_r + 1'b1;
          stable_nxt = consensus;
          pend_nxt   = fresh;
        end
        dtrc_pkg::OP_UPDATE: begin
          relay_nxt = merged;
          ov_nxt    = 1'b1;
          okind_nxt = dtrc_pkg::KIND_DRIVE;
          oword_nxt = merged;
          omask_nxt = upd_mask;
          olast_nxt = 1'b1;
        end
        dtrc_pkg::OP_BULK: begin
          ov_nxt    = 1'b1;
          okind_nxt = dtrc_pkg::KIND_BULK;
          oword_nxt = relay_r;
          omask_nxt = dtrc_pkg::ALL_ONES;
          olast_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan_step) begin
      relay_nxt = toggled;
      pend_nxt  = rest;
      ov_nxt    = 1'b1;
      okind_nxt = dtrc_pkg::KIND_LOCAL;
      oword_nxt = toggled;
      omask_nxt = low;
      olast_nxt = (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r   <= '{default: '0};
      slot_r   <= '0;
      relay_r  <= '0;
      stable_r <= '0;
      pend_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      ring_r   <= ring_nxt;
      slot_r   <= slot_nxt;
      relay_r  <= relay_nxt;
      stable_r <= stable_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    oword_r <= oword_nxt;
    omask_r <= omask_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {omask_r, oword_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  `DTRC_ASSERT(a_scan_has_press, cmd.scan_step |-> (pend_r != '0), "scan with no press pending")
  `DTRC_ASSERT(a_scan_drains, (cmd.scan_step && status.pend_last) |=> (pend_r == '0), "scan did not drain")
  `DTRC_ASSERT(a_no_overwrite, (cmd.scan_step || cmd.accept) |-> status.out_free, "output word overwritten")
  `DTRC_ASSERT(a_relay_in_range, (relay_r & ~dtrc_pkg::CHAN_MASK) == '0, "relay bit beyond channels")

endmodule

// File: rtl/core/debounced_toggle_relay_controller_core.sv
// Top level of the debounced toggle relay controller core.
// Input channel in_*: one word per command. in_tuser carries op (poll, masked
// update, bulk sync, clear dirty); in_tdata carries button_sample, update_mask
// and update_value. Output channel out_*: result words with result_kind in
// out_tuser, relay_word and changed_mask in out_tdata and last_result as
// out_tlast.
// A masked update or bulk sync gives one result, valid the cycle after
// acceptance. A poll with k new debounced presses (up to 32) gives k results,
// lowest button first, one per cycle while the output register is free, once
// the controller has moved to its scan state; a poll with no new press and a
// clear dirty give none. A poll with presses holds the input until the
// one-bit-per-cycle press scan has loaded its last result; the next word can
// be accepted from the cycle after the last result of a poll is loaded.
// The output register holds its word while out_tready is low; the press scan
// and input acceptance pause until it is taken.
// Reset clears the relay word, the sample ring, its write slot and the
// debounced press word; no result is pending after reset.
module debounced_toggle_relay_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // button_sample, update_mask, update_value
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // relay_word, changed_mask
  output logic [1:0]  out_tuser,  // result_kind
  output logic        out_tlast
);

  dtrc_pkg::dp_cmd_t    cmd;
  dtrc_pkg::dp_status_t status;

  dtrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dtrc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: bench/testbench.sv
// Self-checking bench for the debounced toggle relay controller core.
module testbench;
  import dtrc_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int ITEM_TARGET  = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [31:0] changed;
    logic        last;
  } relay_report_t;

  typedef struct packed {
    op_t           op;
    logic [31:0]   sample;
    logic [31:0]   mask;
    logic [31:0]   value;
    logic          fixed;
    relay_report_t report;
  } command_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // button_sample, update_mask, update_value
  logic [1:0]  in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // relay_word, changed_mask
  logic [1:0]  out_tuser;  // result_kind
  logic        out_tlast;

  logic          in_fixed_check;
  relay_report_t in_fixed_report;

  logic [31:0]       expected_relays = '0;
  logic [31:0]       press_history [HISTORY_DEPTH];
  logic [SLOT_W-1:0] history_slot = '0;
  logic [31:0]       debounced_presses = '0;

  relay_report_t relay_reports_due [$];
  relay_report_t step_reports [$];
  command_row_t  directed_rows [21];

  int errors       = 0;
  int reports_seen = 0;
  int cycles       = 0;
  int burst_left   = 0;

  debounced_toggle_relay_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic toggle_and_merge_relays(input op_t op, input logic [31:0] sample,
                                         input logic [31:0] mask,
                                         input logic [31:0] value);
    logic [31:0] agree;
    logic [31:0] fresh;
    logic [31:0] bit_sel;
    logic [31:0] merge_mask;
    int i;
    step_reports.delete();
    case (op)
      OP_POLL: begin
        press_history[history_slot] = sample;
        history_slot = (history_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : history_slot + 1'b1;
        agree = CHAN_MASK;
        for (i = 0; i < HISTORY_DEPTH; i++) agree &= press_history[i];
        fresh = agree & ~debounced_presses;
        for (i = 0; i < 32; i++) begin
          bit_sel = 32'h1 << i;
          if ((fresh & bit_sel) != 0) begin
            expected_relays ^= bit_sel;
            step_reports.push_back('{KIND_LOCAL, expected_relays, bit_sel, 1'b0});
          end
        end
        debounced_presses = agree;
      end
      OP_UPDATE: begin
        merge_mask  = mask & CHAN_MASK;
        expected_relays = ((expected_relays & ~merge_mask) | (value & merge_mask)) & CHAN_MASK;
        step_reports.push_back('{KIND_DRIVE, expected_relays, merge_mask, 1'b0});
      end
      OP_BULK: step_reports.push_back('{KIND_BULK, expected_relays, ALL_ONES, 1'b0});
      default: ;
    endcase
    if (step_reports.size() > 0) step_reports[step_reports.size() - 1].last = 1'b1;
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    relay_report_t got;
    relay_report_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{kind_t'(out_tuser), out_tdata[31:0], out_tdata[63:32], out_tlast};
        reports_seen++;
        if (relay_reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got kind %0d word %h mask %h last %b",
                   $time, got.kind, got.word, got.changed, got.last);
        end else begin
          want = relay_reports_due.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(got.kind));
          check_field("relay_word", want.word, got.word);
          check_field("changed_mask", want.changed, got.changed);
          check_field("last_result", 32'(want.last), 32'(got.last));
        end
      end
      if (in_tvalid && in_tready) begin
        toggle_and_merge_relays(op_t'(in_tuser), in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
        if (in_fixed_check) relay_reports_due.push_back(in_fixed_report);
        else foreach (step_reports[k]) relay_reports_due.push_back(step_reports[k]);
      end
    end
  end

  initial begin : receiver
    logic [15:0] pattern;
    int phase;
    bit held;
    pattern = 16'hFFFF;
    phase = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && reports_seen >= 120 && in_tvalid) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0: pattern = 16'hFFFF;
          1: pattern = 16'($urandom) | 16'h1;
          2: pattern = 16'($urandom & $urandom) | 16'h1;
          default: pattern = 16'(~($urandom & $urandom));
        endcase
      end
      out_tready = pattern[phase % 16];
      phase = (phase + 1) % 64;
    end
  end

  task automatic push_command(input command_row_t row);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid       = 1'b1;
    in_tuser        = row.op;
    in_tdata        = {row.value, row.mask, row.sample};
    in_fixed_check  = row.fixed;
    in_fixed_report = row.report;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (relay_reports_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    command_row_t cmd;
    logic [31:0] held_buttons;
    int items_sent;
    int next_drain;
    int reps;
    int k;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tuser        = OP_CLEAR;
    in_tdata        = '0;
    in_fixed_check  = 1'b0;
    in_fixed_report = '0;
    for (k = 0; k < HISTORY_DEPTH; k++) press_history[k] = '0;
    directed_rows = '{
      '{OP_BULK,   32'h0, 32'h0, 32'h0, 1'b1, '{KIND_BULK, 32'h0, ALL_ONES, 1'b1}},
      '{OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{KIND_DRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
      '{OP_UPDATE, 32'h0, 32'h0, 32'h0, 1'b1, '{KIND_DRIVE, 32'hFFFF_FFFF, 32'h0, 1'b1}},
      '{OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, '{KIND_DRIVE, 32'h0, 32'hFFFF_FFFF, 1'b1}},
      '{OP_POLL,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
      '{OP_BULK,   32'h0, 32'h0, 32'h0, 1'b1, '{KIND_BULK, 32'hFFFF_FFFF, ALL_ONES, 1'b1}},
      '{OP_POLL,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h8000_0001, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h8000_0001, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h8000_0001, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h8000_0001, 32'h0, 32'h0, 1'b0, '0},
      '{OP_POLL,   32'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'h0000_FFFF, 32'h1234_5678, 1'b0, '0},
      '{OP_BULK,   32'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OP_CLEAR,  32'h0, 32'h0, 32'h0, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) push_command(directed_rows[i]);
    drain_reports();

    items_sent = 0;
    next_drain = 150;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          held_buttons = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom & $urandom & $urandom);
          reps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 6);
          for (k = 0; k < reps; k++) begin
            cmd = '{OP_POLL, held_buttons | ($urandom & $urandom & $urandom & $urandom),
                    $urandom, $urandom, 1'b0, '0};
            push_command(cmd);
            items_sent++;
          end
          for (k = $urandom_range(0, 2); k > 0; k--) begin
            cmd = '{OP_POLL, ($urandom_range(0, 1) == 0) ? 32'h0 : ($urandom & ~held_buttons),
                    $urandom, $urandom, 1'b0, '0};
            push_command(cmd);
            items_sent++;
          end
        end
        [55:69]: begin
          cmd = '{OP_UPDATE, $urandom, $urandom, $urandom, 1'b0, '0};
          case ($urandom_range(0, 3))
            0: cmd.mask = '0;
            1: cmd.mask = ALL_ONES;
            2: cmd.mask = $urandom & $urandom;
            default: ;
          endcase
          push_command(cmd);
          items_sent++;
        end
        [70:79]: begin
          cmd = '{OP_BULK, $urandom, $urandom, $urandom, 1'b0, '0};
          push_command(cmd);
          items_sent++;
        end
        [80:87]: begin
          cmd = '{OP_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0};
          push_command(cmd);
        end
        default: begin
          cmd = '{OP_POLL, $urandom, $urandom, $urandom, 1'b0, '0};
          push_command(cmd);
          items_sent++;
        end
      endcase
      if (items_sent >= next_drain) begin
        drain_reports();
        next_drain += 150;
      end
    end

    in_tvalid = 1'b0;
    while (relay_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
